@@ hw/rtl/sal_pkg.sv @@
package sal_pkg;

	localparam int KEY_W       = 32;
	localparam int VALUE_W     = 64;
	localparam int HEADER_W    = 32;
	localparam int TIME_W      = 32;
	localparam int START_W     = 16;
	localparam int COUNT_W     = 7;
	localparam int STATUS_W    = 2;
	localparam int OFFSET_W    = 9;
	localparam int END_W       = 10;
	localparam int SEGS_W      = 4;
	localparam int IN_DATA_W   = 184;
	localparam int OUT_DATA_W  = 184;
	localparam int MAX_READ    = 64;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_DEPTH   = 4;
	localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

	localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RECORD   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic                is_read;
		logic [KEY_W-1:0]    key;
		logic [VALUE_W-1:0]  value;
		logic [HEADER_W-1:0] header;
		logic [TIME_W-1:0]   tstamp;
		logic [START_W-1:0]  start;
		logic [COUNT_W-1:0]  want;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFFSET_W-1:0] offset;
		logic [KEY_W-1:0]    key;
		logic [VALUE_W-1:0]  value;
		logic [HEADER_W-1:0] header;
		logic [TIME_W-1:0]   tstamp;
		logic [END_W-1:0]    end_offset;
		logic [SEGS_W-1:0]   segs;
		logic                last;
	} result_t;

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} back_state_t;

endpackage

@@ hw/rtl/segmented_append_log.sv @@
// A result passes through the command queue, the memory read stage and the output
// queue, each registered. Throughput: one command per cycle while the output queue
// has room and no read is under way; a read gives one record per cycle, set by the
// single read port of the record memory and the room left in the output queue.
// Reset: arst_n clears the counters, queues and sequencer at once; the record
// memory is not cleared, as only entries already written are ever read.
module segmented_append_log
	import sal_pkg::*;
#(
	parameter int SEGMENT_SLOTS       = 8,
	parameter int RECORDS_PER_SEGMENT = 64
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// key_word, value_word, header_word, time_stamp, first read offset, max_count, pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// command
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// record_offset, out_key, out_value, out_header, out_time, end_offset,
	// segments_used, pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [STATUS_W-1:0]   m_tuser,
	output logic                  m_tlast
);

	logic                 q_valid;
	cmd_t                 q_cmd;
	logic                 q_pop;
	logic [OUT_CNT_W-1:0] out_fill;
	logic                 res_valid;
	result_t              res_data;

	sal_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	sal_back #(
		.SEGMENT_SLOTS       (SEGMENT_SLOTS),
		.RECORDS_PER_SEGMENT (RECORDS_PER_SEGMENT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.out_fill  (out_fill),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	sal_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_data  (res_data),
		.out_fill  (out_fill),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

@@ hw/rtl/sal_front.sv @@
module sal_front
	import sal_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	output logic                 q_valid,
	output cmd_t                 q_cmd,
	input  logic                 q_pop
);

	cmd_t                   queue_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	cmd_t                   cmd_in;
	logic                   push;
	logic                   pop;

	// Decode the transfer and clamp the read length once, so the back end
	// only sees a count it can step down directly.
	always_comb begin
		cmd_in.is_read = s_tuser;
		cmd_in.key     = s_tdata[31:0];
		cmd_in.value   = s_tdata[95:32];
		cmd_in.header  = s_tdata[127:96];
		cmd_in.tstamp  = s_tdata[159:128];
		cmd_in.start   = s_tdata[175:160];
		if (s_tdata[182:176] > COUNT_W'(MAX_READ)) begin
			cmd_in.want = COUNT_W'(MAX_READ);
		end else begin
			cmd_in.want = s_tdata[182:176];
		end
	end

	assign s_tready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_cmd    = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

@@ hw/rtl/sal_back.sv @@
module sal_back
	import sal_pkg::*;
#(
	parameter int SEGMENT_SLOTS       = 8,
	parameter int RECORDS_PER_SEGMENT = 64
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  cmd_t                 q_cmd,
	output logic                 q_pop,
	input  logic [OUT_CNT_W-1:0] out_fill,
	output logic                 res_valid,
	output result_t              res_data
);

	localparam int CAPACITY = SEGMENT_SLOTS * RECORDS_PER_SEGMENT;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int SEG_W    = $clog2(SEGMENT_SLOTS + 1);
	localparam int CMP_W    = (CNT_W > START_W) ? CNT_W : START_W;

	logic [2*KEY_W-1:0]   rec_mem  [CAPACITY];
	logic [VALUE_W-1:0]   val_mem  [CAPACITY];
	logic [TIME_W-1:0]    time_mem [CAPACITY];

	back_state_t          state_q;
	back_state_t          state_d;
	logic [CNT_W-1:0]     cnt_q;
	logic [SEG_W-1:0]     seg_q;
	logic [ADDR_W-1:0]    idx_q;
	logic [COUNT_W-1:0]   remain_q;

	logic                 issue_ok;
	logic                 issue;
	logic                 wr_en;
	logic                 roll;
	logic                 rd_en;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 rd_start;
	logic                 rd_step;
	logic                 res_last;
	logic [STATUS_W-1:0]  res_status;
	logic [OFFSET_W-1:0]  res_offset;
	logic [END_W-1:0]     res_end;
	logic [SEGS_W-1:0]    res_segs;
	logic [CNT_W-1:0]     seg_cap;

	logic                 valid_s1;
	logic                 from_mem_s1;
	logic [STATUS_W-1:0]  status_s1;
	logic [OFFSET_W-1:0]  offset_s1;
	logic [END_W-1:0]     end_s1;
	logic [SEGS_W-1:0]    segs_s1;
	logic                 last_s1;
	logic [2*KEY_W-1:0]   rec_s1;
	logic [VALUE_W-1:0]   val_s1;
	logic [TIME_W-1:0]    time_s1;

	// A result may only be started when the output queue is sure to have
	// room for it, counting the one still in the read stage.
	assign issue_ok = ({1'b0, out_fill} + (OUT_CNT_W + 1)'(valid_s1))
	                  < (OUT_CNT_W + 1)'(OUT_DEPTH);
	assign seg_cap  = CNT_W'(seg_q * RECORDS_PER_SEGMENT);

	always_comb begin
		q_pop      = 1'b0;
		issue      = 1'b0;
		wr_en      = 1'b0;
		roll       = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = idx_q;
		rd_start   = 1'b0;
		rd_step    = 1'b0;
		res_last   = 1'b1;
		res_status = ST_EMPTY;
		res_offset = '0;
		res_end    = END_W'(cnt_q);
		res_segs   = SEGS_W'(seg_q);
		case (state_q)
			BK_IDLE: begin
				if (q_valid && issue_ok) begin
					q_pop = 1'b1;
					issue = 1'b1;
					if (!q_cmd.is_read) begin
						if (cnt_q == seg_cap && seg_q >= SEG_W'(SEGMENT_SLOTS)) begin
							res_status = ST_FULL;
						end else begin
							// The active segment is full: open the next one first.
							roll       = (cnt_q == seg_cap);
							wr_en      = 1'b1;
							res_status = ST_APPENDED;
							res_offset = OFFSET_W'(cnt_q);
							res_end    = END_W'(cnt_q + CNT_W'(1));
							res_segs   = SEGS_W'(seg_q + SEG_W'(roll));
						end
					end else if (CMP_W'(q_cmd.start) >= CMP_W'(cnt_q) ||
					             q_cmd.want == '0) begin
						res_status = ST_EMPTY;
					end else begin
						rd_en      = 1'b1;
						rd_start   = 1'b1;
						rd_addr    = ADDR_W'(q_cmd.start);
						res_status = ST_RECORD;
						res_offset = OFFSET_W'(q_cmd.start);
						res_last   = (q_cmd.want == COUNT_W'(1)) ||
						             (CNT_W'(q_cmd.start) + CNT_W'(1) == cnt_q);
					end
				end
			end
			BK_READ: begin
				if (issue_ok) begin
					issue      = 1'b1;
					rd_en      = 1'b1;
					rd_step    = 1'b1;
					rd_addr    = idx_q;
					res_status = ST_RECORD;
					res_offset = OFFSET_W'(idx_q);
					res_last   = (remain_q == COUNT_W'(1)) ||
					             (CNT_W'(idx_q) + CNT_W'(1) == cnt_q);
				end
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (rd_start && !res_last) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				if (rd_step && res_last) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rec_mem[ADDR_W'(cnt_q)]  <= {q_cmd.key, q_cmd.header};
			val_mem[ADDR_W'(cnt_q)]  <= q_cmd.value;
			time_mem[ADDR_W'(cnt_q)] <= q_cmd.tstamp;
		end
		if (rd_en) begin
			rec_s1  <= rec_mem[rd_addr];
			val_s1  <= val_mem[rd_addr];
			time_s1 <= time_mem[rd_addr];
		end
		if (issue) begin
			from_mem_s1 <= rd_en;
			status_s1   <= res_status;
			offset_s1   <= res_offset;
			end_s1      <= res_end;
			segs_s1     <= res_segs;
			last_s1     <= res_last;
		end
		if (rd_start) begin
			idx_q    <= ADDR_W'(q_cmd.start) + ADDR_W'(1);
			remain_q <= q_cmd.want - COUNT_W'(1);
		end else if (rd_step) begin
			idx_q    <= idx_q + ADDR_W'(1);
			remain_q <= remain_q - COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			cnt_q    <= '0;
			seg_q    <= SEG_W'(1);
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (wr_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (roll) begin
				seg_q <= seg_q + SEG_W'(1);
			end
		end
	end

	always_comb begin
		res_valid           = valid_s1;
		res_data.status     = status_s1;
		res_data.offset     = offset_s1;
		res_data.end_offset = end_s1;
		res_data.segs       = segs_s1;
		res_data.last       = last_s1;
		if (from_mem_s1) begin
			res_data.key    = rec_s1[2*KEY_W-1:KEY_W];
			res_data.header = rec_s1[HEADER_W-1:0];
			res_data.value  = val_s1;
			res_data.tstamp = time_s1;
		end else begin
			res_data.key    = '0;
			res_data.header = '0;
			res_data.value  = '0;
			res_data.tstamp = '0;
		end
	end

endmodule

@@ hw/rtl/sal_out.sv @@
module sal_out
	import sal_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_valid,
	input  result_t               res_data,
	output logic [OUT_CNT_W-1:0]  out_fill,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [STATUS_W-1:0]   m_tuser,
	output logic                  m_tlast
);

	result_t              fifo_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] count_q;
	result_t              head;
	logic                 pop;

	// The back end never pushes without room, so no full check is needed here.
	assign m_tvalid  = (count_q != '0);
	assign pop       = m_tvalid && m_tready;
	assign out_fill  = count_q;
	assign head      = fifo_q[rd_ptr_q];

	assign m_tuser = head.status;
	assign m_tlast = head.last;
	assign m_tdata = {1'b0, head.segs, head.end_offset, head.tstamp, head.header,
	                  head.value, head.key, head.offset};

	always_ff @(posedge clk) begin
		if (res_valid) begin
			fifo_q[wr_ptr_q] <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			if (res_valid && !pop) begin
				count_q <= count_q + OUT_CNT_W'(1);
			end else if (pop && !res_valid) begin
				count_q <= count_q - OUT_CNT_W'(1);
			end
		end
	end

endmodule

@@ tb/sv/segmented_append_log_tb.sv @@
module segmented_append_log_tb;
	import sal_pkg::*;

	localparam int SEG_SLOTS    = 8;
	localparam int PER_SEGMENT  = 64;
	localparam int CAPACITY     = SEG_SLOTS * PER_SEGMENT;
	localparam int RANDOM_ITEMS = 430;
	localparam int LIMIT_CYCLES = 1_000_000;

	typedef struct {
		bit                  rd;
		logic [KEY_W-1:0]    key;
		logic [VALUE_W-1:0]  value;
		logic [HEADER_W-1:0] header;
		logic [TIME_W-1:0]   tstamp;
		logic [START_W-1:0]  start;
		logic [COUNT_W-1:0]  want;
		bit                  known;
		logic [STATUS_W-1:0] status;
		int                  offset;
		int                  end_offset;
		int                  segs;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]   m_tuser;
	logic                  m_tlast;

	// Shadow copy of the log, kept in step with accepted commands.
	logic [KEY_W-1:0]    shadow_key    [0:CAPACITY-1];
	logic [VALUE_W-1:0]  shadow_value  [0:CAPACITY-1];
	logic [HEADER_W-1:0] shadow_header [0:CAPACITY-1];
	logic [TIME_W-1:0]   shadow_time   [0:CAPACITY-1];
	int unsigned         shadow_count;
	int unsigned         shadow_segs;

	result_t     log_results_due[$];
	result_t     head;
	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned burst_left;
	int unsigned stall_left;
	int unsigned ready_mode;
	int unsigned mode_age;
	dir_row_t    dir_rows[13];

	segmented_append_log u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
		mismatches++;
	endtask

	// Applies one accepted command to the shadow log and, when keep is set, queues the transfers it causes.
	task automatic predict_log_item(input cmd_t c, input bit keep);
		result_t     r;
		int unsigned span;
		int unsigned n;
		r = '0;
		r.last = 1'b1;
		if (!c.is_read) begin
			if (shadow_count >= shadow_segs * PER_SEGMENT && shadow_segs < SEG_SLOTS)
				shadow_segs++;
			if (shadow_count >= shadow_segs * PER_SEGMENT) begin
				r.status = ST_FULL;
			end else begin
				shadow_key[shadow_count]    = c.key;
				shadow_value[shadow_count]  = c.value;
				shadow_header[shadow_count] = c.header;
				shadow_time[shadow_count]   = c.tstamp;
				r.status = ST_APPENDED;
				r.offset = OFFSET_W'(shadow_count);
				shadow_count++;
			end
			r.end_offset = END_W'(shadow_count);
			r.segs       = SEGS_W'(shadow_segs);
			if (keep)
				log_results_due.push_back(r);
		end else begin
			span = (c.want > MAX_READ) ? MAX_READ : c.want;
			r.end_offset = END_W'(shadow_count);
			r.segs       = SEGS_W'(shadow_segs);
			if (c.start >= shadow_count || span == 0) begin
				r.status = ST_EMPTY;
				if (keep)
					log_results_due.push_back(r);
			end else begin
				n = shadow_count - c.start;
				if (n > span)
					n = span;
				for (int unsigned i = 0; i < n; i++) begin
					r.status = ST_RECORD;
					r.offset = OFFSET_W'(c.start + i);
					r.key    = shadow_key[c.start + i];
					r.value  = shadow_value[c.start + i];
					r.header = shadow_header[c.start + i];
					r.tstamp = shadow_time[c.start + i];
					r.last   = (i + 1 == n);
					if (keep)
						log_results_due.push_back(r);
				end
			end
		end
	endtask

	// Sender side: bursts of back-to-back transfers separated by random gaps.
	task automatic send_command(input cmd_t c, input bit known, input result_t fixed);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, c.want, c.start, c.tstamp, c.header, c.value, c.key};
		s_tuser  <= c.is_read;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_log_item(c, !known);
		if (known)
			log_results_due.push_back(fixed);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (log_results_due.size() != 0);
	endtask

	function automatic cmd_t random_log_command();
		cmd_t c;
		int unsigned pick;
		c.key    = $urandom;
		c.value  = {$urandom, $urandom};
		c.header = $urandom;
		c.tstamp = $urandom;
		c.start  = START_W'($urandom);
		c.want   = COUNT_W'($urandom);
		// Fill the log fairly quickly so that segment rolls are reached.
		if (shadow_count < CAPACITY)
			c.is_read = ($urandom_range(0, 99) >= 80);
		else
			c.is_read = ($urandom_range(0, 99) >= 30);
		if (c.is_read) begin
			pick = $urandom_range(0, 99);
			if (pick < 65 && shadow_count > 0)
				c.start = START_W'($urandom_range(0, shadow_count - 1));
			else if (pick < 80)
				c.start = START_W'(shadow_count + $urandom_range(0, 2));
			pick = $urandom_range(0, 99);
			if (pick < 8)
				c.want = '0;
			else if (pick < 18)
				c.want = COUNT_W'($urandom_range(MAX_READ + 1, 127));
			else if (pick < 60)
				c.want = COUNT_W'($urandom_range(1, 8));
			else
				c.want = COUNT_W'($urandom_range(1, MAX_READ));
		end
		return c;
	endfunction

	// Receiver side: the stall pattern changes character each time its mode age runs out.
	always @(posedge clk) begin
		if (mode_age == 0) begin
			ready_mode = $urandom_range(0, 2);
			mode_age   = $urandom_range(50, 300);
		end else begin
			mode_age--;
		end
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			case (ready_mode)
				1: if ($urandom_range(0, 3) == 0) stall_left = 1;
				2: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
				default: stall_left = 0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (log_results_due.size() == 0) begin
				report_mismatch("transfer with nothing due, status", m_tuser, 0);
			end else begin
				head = log_results_due.pop_front();
				if (m_tuser !== head.status)
					report_mismatch("status", m_tuser, head.status);
				if (m_tdata[8:0] !== head.offset)
					report_mismatch("record_offset", m_tdata[8:0], head.offset);
				if (m_tdata[40:9] !== head.key)
					report_mismatch("out_key", m_tdata[40:9], head.key);
				if (m_tdata[104:41] !== head.value)
					report_mismatch("out_value", m_tdata[104:41], head.value);
				if (m_tdata[136:105] !== head.header)
					report_mismatch("out_header", m_tdata[136:105], head.header);
				if (m_tdata[168:137] !== head.tstamp)
					report_mismatch("out_time", m_tdata[168:137], head.tstamp);
				if (m_tdata[178:169] !== head.end_offset)
					report_mismatch("end_offset", m_tdata[178:169], head.end_offset);
				if (m_tdata[182:179] !== head.segs)
					report_mismatch("segments_used", m_tdata[182:179], head.segs);
				if (m_tlast !== head.last)
					report_mismatch("last", m_tlast, head.last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		cmd_t        c;
		result_t     fixed;
		int unsigned sent;
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = 1'b0;
		m_tready     = 1'b0;
		shadow_count = 0;
		shadow_segs  = 1;
		mismatches   = 0;
		cycle_count  = 0;
		burst_left   = 0;
		stall_left   = 0;
		ready_mode   = 0;
		mode_age     = 0;

		dir_rows = '{
			'{1'b1, 32'h0, 64'h0, 32'h0, 32'h0, 16'h0000, 7'd1,
				1'b1, ST_EMPTY, 0, 0, 1},
			'{1'b0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
				16'hFFFF, 7'h7F, 1'b1, ST_APPENDED, 0, 1, 1},
			'{1'b0, 32'h0, 64'h0, 32'h0, 32'h0, 16'h0000, 7'd0,
				1'b1, ST_APPENDED, 1, 2, 1},
			'{1'b1, 32'h0, 64'h0, 32'h0, 32'h0, 16'h0000, 7'd0,
				1'b1, ST_EMPTY, 0, 2, 1},
			'{1'b1, 32'h0, 64'h0, 32'h0, 32'h0, 16'h0000, 7'd127,
				1'b0, ST_RECORD, 0, 0, 0},
			'{1'b1, 32'h0, 64'h0, 32'h0, 32'h0, 16'hFFFF, 7'd64,
				1'b1, ST_EMPTY, 0, 2, 1},
			'{1'b1, 32'h0, 64'h0, 32'h0, 32'h0, 16'h0002, 7'd5,
				1'b1, ST_EMPTY, 0, 2, 1},
			'{1'b1, 32'h0, 64'h0, 32'h0, 32'h0, 16'h0001, 7'd1,
				1'b0, ST_RECORD, 0, 0, 0},
			'{1'b0, 32'h0123_4567, 64'h89AB_CDEF_0246_8ACE, 32'h1357_9BDF, 32'h5A5A_A5A5,
				16'h0000, 7'd0, 1'b1, ST_APPENDED, 2, 3, 1},
			'{1'b1, 32'h0, 64'h0, 32'h0, 32'h0, 16'h0000, 7'd64,
				1'b0, ST_RECORD, 0, 0, 0},
			'{1'b1, 32'h0, 64'h0, 32'h0, 32'h0, 16'h0000, 7'd65,
				1'b0, ST_RECORD, 0, 0, 0},
			'{1'b1, 32'h0, 64'h0, 32'h0, 32'h0, 16'h8000, 7'd40,
				1'b1, ST_EMPTY, 0, 3, 1},
			'{1'b1, 32'h0, 64'h0, 32'h0, 32'h0, 16'h0002, 7'd2,
				1'b0, ST_RECORD, 0, 0, 0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			c.is_read = dir_rows[i].rd;
			c.key     = dir_rows[i].key;
			c.value   = dir_rows[i].value;
			c.header  = dir_rows[i].header;
			c.tstamp  = dir_rows[i].tstamp;
			c.start   = dir_rows[i].start;
			c.want    = dir_rows[i].want;
			fixed            = '0;
			fixed.status     = dir_rows[i].status;
			fixed.offset     = OFFSET_W'(dir_rows[i].offset);
			fixed.end_offset = END_W'(dir_rows[i].end_offset);
			fixed.segs       = SEGS_W'(dir_rows[i].segs);
			fixed.last       = 1'b1;
			send_command(c, dir_rows[i].known, fixed);
		end

		// Let the log go quiet once before the random traffic starts.
		hold_until_drained();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			send_command(random_log_command(), 1'b0, '0);
			sent++;
			if (sent % 97 == 50)
				hold_until_drained();
		end

		hold_until_drained();
		repeat (10) @(posedge clk);
		if (log_results_due.size() != 0)
			report_mismatch("transfers still due", log_results_due.size(), 0);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
